// ----- hdl/triangle_barycentric_weights_top_assert.svh -----
// Assertion macros for the barycentric weights block.
// Used by the checker module; needs no other file.
`ifndef TRIANGLE_BARYCENTRIC_WEIGHTS_TOP_ASSERT_SVH
`define TRIANGLE_BARYCENTRIC_WEIGHTS_TOP_ASSERT_SVH
// Implication checked every clock outside reset.
`define TBW_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TBW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/tbw_pkg.sv -----
// Shared constants, types and helpers for the barycentric weights block.
// No dependencies.
package tbw_pkg;
  localparam int CoordWidthDef = 16;
  localparam int LimitWidth    = 16;
  localparam int WeightWidth   = 24;
  localparam int FracBits      = 16;
  localparam int QuotBits      = 27;
  localparam logic [LimitWidth-1:0] LimitReset = 16'd2;
  localparam logic signed [WeightWidth-1:0] WeightOne    = 24'sd65536;
  localparam logic signed [WeightWidth-1:0] WeightNegOne = -24'sd65536;
  localparam logic signed [WeightWidth-1:0] WeightMax    = 24'sd8388607;
  localparam logic signed [WeightWidth-1:0] WeightMin    = -24'sd8388608;

  // Sideband that travels beside the divider payload.
  typedef struct packed {
    logic degenerate;
    logic neg_s;
    logic neg_y;
    logic neg_x;
  } tbw_side_t;

  // Saturate a 29-bit signed value to the 24-bit weight range.
  function automatic logic signed [WeightWidth-1:0] sat24(input logic signed [28:0] v);
    logic signed [28:0] hi;
    logic signed [28:0] lo;
    hi = 29'(WeightMax);
    lo = 29'(WeightMin);
    if (v > hi) sat24 = WeightMax;
    else if (v < lo) sat24 = WeightMin;
    else sat24 = v[WeightWidth-1:0];
  endfunction
endpackage

// ----- hdl/tbw_cross.sv -----
// Edge differences, cross product and degenerate test, three register stages.
// Depends on tbw_pkg.
module tbw_cross import tbw_pkg::*; #(
  parameter int CW = CoordWidthDef,
  parameter int PW = 2*CW+4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic signed [CW-1:0]   x1, y1, x2, y2, x3, y3, px, py,
  input  logic [LimitWidth-1:0]  limit,
  output logic                   out_valid,
  output logic [PW-1:0]          mag_s, mag_y, mag_x, mag_z,
  output tbw_side_t              side
);
  localparam int DW = CW + 1;
  localparam int MW = 2*DW;
  logic [2:0] vld;
  logic signed [DW-1:0] ax, ay, az, bx, by, bz;
  logic signed [MW-1:0] p_ay_bz, p_az_by, p_az_bx, p_ax_bz, p_ax_by, p_ay_bx;
  logic signed [PW-1:0] cx, cy, cz, cs;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[1:0], in_valid};
    // stage 1: differences
    ax <= DW'(x3) - DW'(x1);
    ay <= DW'(x2) - DW'(x1);
    az <= DW'(x1) - DW'(px);
    bx <= DW'(y3) - DW'(y1);
    by <= DW'(y2) - DW'(y1);
    bz <= DW'(y1) - DW'(py);
    // stage 2: products
    p_ay_bz <= ay * bz;
    p_az_by <= az * by;
    p_az_bx <= az * bx;
    p_ax_bz <= ax * bz;
    p_ax_by <= ax * by;
    p_ay_bx <= ay * bx;
    // stage 3: cross terms, magnitudes, signs
    mag_x <= cx[PW-1] ? PW'(-cx) : cx;
    mag_y <= cy[PW-1] ? PW'(-cy) : cy;
    mag_s <= cs[PW-1] ? PW'(-cs) : cs;
    mag_z <= cz[PW-1] ? PW'(-cz) : cz;
    side.neg_x <= cx[PW-1] ^ cz[PW-1];
    side.neg_y <= cy[PW-1] ^ cz[PW-1];
    side.neg_s <= cs[PW-1] ^ cz[PW-1];
    side.degenerate <= ((cz[PW-1] ? PW'(-cz) : cz) <= PW'(limit));
  end

  always_comb begin
    cx = PW'(p_ay_bz) - PW'(p_az_by);
    cy = PW'(p_az_bx) - PW'(p_ax_bz);
    cz = PW'(p_ax_by) - PW'(p_ay_bx);
    cs = cx + cy;
  end

  assign out_valid = vld[2];
endmodule

// ----- hdl/tbw_div.sv -----
// Pipelined restoring divider: three quotients of QuotBits bits, one bit a stage.
// Depends on tbw_pkg.
module tbw_div import tbw_pkg::*; #(
  parameter int PW = 36
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [PW-1:0]      num_s, num_y, num_x, den,
  input  tbw_side_t          side_in,
  output logic               out_valid,
  output logic [QuotBits-1:0] q_s, q_y, q_x,
  output tbw_side_t          side_out
);
  // Numerator scaled by 2^16, remainders kept wide enough for den << 26.
  localparam int NW = PW + FracBits;
  localparam int RW = NW + QuotBits;
  localparam int NS = QuotBits;

  logic [NS-1:0]        vld;
  logic [RW-1:0]        rs [NS], ry [NS], rx [NS];
  logic [PW-1:0]        dn [NS];
  logic [QuotBits-1:0]  qs [NS], qy [NS], qx [NS];
  tbw_side_t            sd [NS];
  logic [RW-1:0]        rs_in, ry_in, rx_in;

  assign rs_in = RW'({num_s, {FracBits{1'b0}}});
  assign ry_in = RW'({num_y, {FracBits{1'b0}}});
  assign rx_in = RW'({num_x, {FracBits{1'b0}}});

  // One restoring step: subtract den << sh when it fits; top bit is the quotient bit.
  function automatic logic [RW:0] div_step(input logic [RW-1:0] r, input logic [PW-1:0] d,
                                           input int sh);
    logic [RW-1:0] t;
    t = RW'(d) << sh;
    if (r >= t) div_step = {1'b1, r - t};
    else div_step = {1'b0, r};
  endfunction

  // Stage 0 is the saturation test (num << 16 >= den << 26); its bit lands in the
  // quotient MSB as the bits shift in, and the output forces exactly 2^26.
  always_ff @(posedge clk) begin
    logic [RW:0] st_s, st_y, st_x;
    if (rst) vld <= '0;
    else vld <= {vld[NS-2:0], in_valid};
    st_s = div_step(rs_in, den, NS - 1);
    st_y = div_step(ry_in, den, NS - 1);
    st_x = div_step(rx_in, den, NS - 1);
    rs[0] <= st_s[RW-1:0];
    ry[0] <= st_y[RW-1:0];
    rx[0] <= st_x[RW-1:0];
    qs[0] <= {{(QuotBits-1){1'b0}}, st_s[RW]};
    qy[0] <= {{(QuotBits-1){1'b0}}, st_y[RW]};
    qx[0] <= {{(QuotBits-1){1'b0}}, st_x[RW]};
    dn[0] <= den;
    sd[0] <= side_in;
    for (int i = 1; i < NS; i++) begin
      st_s = div_step(rs[i-1], dn[i-1], NS - 1 - i);
      st_y = div_step(ry[i-1], dn[i-1], NS - 1 - i);
      st_x = div_step(rx[i-1], dn[i-1], NS - 1 - i);
      rs[i] <= st_s[RW-1:0];
      ry[i] <= st_y[RW-1:0];
      rx[i] <= st_x[RW-1:0];
      qs[i] <= {qs[i-1][QuotBits-2:0], st_s[RW]};
      qy[i] <= {qy[i-1][QuotBits-2:0], st_y[RW]};
      qx[i] <= {qx[i-1][QuotBits-2:0], st_x[RW]};
      dn[i] <= dn[i-1];
      sd[i] <= sd[i-1];
    end
  end

  assign out_valid = vld[NS-1];
  // Saturation case gives exactly 2^26: drop any lower bits.
  assign q_s = qs[NS-1][QuotBits-1] ? (QuotBits'(1) << (QuotBits-1)) : qs[NS-1];
  assign q_y = qy[NS-1][QuotBits-1] ? (QuotBits'(1) << (QuotBits-1)) : qy[NS-1];
  assign q_x = qx[NS-1][QuotBits-1] ? (QuotBits'(1) << (QuotBits-1)) : qx[NS-1];
  assign side_out = sd[NS-1];
endmodule

// ----- hdl/tbw_out.sv -----
// Sign restore, one-minus, saturation and degenerate override; one register stage.
// Depends on tbw_pkg.
module tbw_out import tbw_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [QuotBits-1:0]           q_s, q_y, q_x,
  input  tbw_side_t                     side,
  output logic                          done,
  output logic signed [WeightWidth-1:0] w1, w2, w3,
  output logic                          degen
);
  logic signed [28:0] ss, sy, sx, one_minus;

  always_comb begin
    ss = side.neg_s ? -29'($signed({1'b0, q_s})) : 29'($signed({1'b0, q_s}));
    sy = side.neg_y ? -29'($signed({1'b0, q_y})) : 29'($signed({1'b0, q_y}));
    sx = side.neg_x ? -29'($signed({1'b0, q_x})) : 29'($signed({1'b0, q_x}));
    one_minus = 29'(WeightOne) - ss;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= in_valid;
    degen <= side.degenerate;
    if (side.degenerate) begin
      w1 <= WeightNegOne;
      w2 <= WeightOne;
      w3 <= WeightOne;
    end else begin
      w1 <= sat24(one_minus);
      w2 <= sat24(sy);
      w3 <= sat24(sx);
    end
  end
endmodule

// ----- hdl/triangle_barycentric_weights_top.sv -----
// Top level of the barycentric weights block: cross product, divider, output.
// Depends on tbw_pkg, tbw_cross, tbw_div, tbw_out.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  request   | start / busy       | first_x .. pixel_y (COORD_WIDTH each)
//  result    | done (one cycle)   | weight_first/second/third, degenerate
//  config    | limit_we           | limit_wdata (degenerate_limit)
//
// The path runs through differences, products and cross terms, then the
// bit-per-stage quotient pipeline, then saturation and output.
// A new request is taken every cycle; busy is tied low.
// Synchronous reset clears valid bits and sets the limit to 2.
// The receiver cannot stall, so results leave as they arrive.
module triangle_barycentric_weights_top import tbw_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] third_x,
  input  logic signed [COORD_WIDTH-1:0] third_y,
  input  logic signed [COORD_WIDTH-1:0] pixel_x,
  input  logic signed [COORD_WIDTH-1:0] pixel_y,
  input  logic                          limit_we,
  input  logic [LimitWidth-1:0]         limit_wdata,
  output logic                          done,
  output logic signed [WeightWidth-1:0] weight_first,
  output logic signed [WeightWidth-1:0] weight_second,
  output logic signed [WeightWidth-1:0] weight_third,
  output logic                          degenerate
);
  // Cross terms need 2*(COORD_WIDTH+1)+2 bits; magnitudes fit the same width.
  localparam int PW = 2*COORD_WIDTH + 4;

  logic [LimitWidth-1:0] degenerate_limit;
  logic                  cr_valid, dv_valid;
  logic [PW-1:0]         mag_s, mag_y, mag_x, mag_z;
  tbw_side_t             cr_side, dv_side;
  logic [QuotBits-1:0]   q_s, q_y, q_x;

  // Hold the limit register; the user must write it only while idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) degenerate_limit <= LimitReset;
    else if (limit_we) degenerate_limit <= limit_wdata;
  end

  // Fully pipelined: never refuse a request.
  assign busy = 1'b0;

  tbw_cross #(.CW(COORD_WIDTH), .PW(PW)) u_cross (
    .clk, .rst, .in_valid(start & ~busy),
    .x1(first_x), .y1(first_y), .x2(second_x), .y2(second_y),
    .x3(third_x), .y3(third_y), .px(pixel_x), .py(pixel_y),
    .limit(degenerate_limit), .out_valid(cr_valid),
    .mag_s, .mag_y, .mag_x, .mag_z, .side(cr_side)
  );

  // A degenerate item may carry a zero divisor; its quotients are discarded.
  tbw_div #(.PW(PW)) u_div (
    .clk, .rst, .in_valid(cr_valid),
    .num_s(mag_s), .num_y(mag_y), .num_x(mag_x), .den(mag_z),
    .side_in(cr_side), .out_valid(dv_valid),
    .q_s, .q_y, .q_x, .side_out(dv_side)
  );

  tbw_out u_out (
    .clk, .rst, .in_valid(dv_valid), .q_s, .q_y, .q_x, .side(dv_side),
    .done, .w1(weight_first), .w2(weight_second), .w3(weight_third),
    .degen(degenerate)
  );
endmodule

// ----- hdl/tbw_checker.sv -----
// Port-level checker for the barycentric weights block, with its bind.
// Depends on tbw_pkg and triangle_barycentric_weights_top_assert.svh.
`include "triangle_barycentric_weights_top_assert.svh"
module tbw_checker import tbw_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic signed [WeightWidth-1:0] weight_first,
  input logic signed [WeightWidth-1:0] weight_second,
  input logic signed [WeightWidth-1:0] weight_third,
  input logic                          degenerate
);
  `TBW_ASSERT_IMP(a_degen_triple, clk, rst, done && degenerate,
    weight_first == WeightNegOne && weight_second == WeightOne && weight_third == WeightOne)
  `TBW_ASSERT_IMP(a_never_busy, clk, rst, start, !busy)
  `TBW_ASSERT_NEXT(a_no_done_after_reset, clk, rst, $fell(rst), !done)
endmodule

bind triangle_barycentric_weights_top tbw_checker u_tbw_checker (
  .clk, .rst, .start, .busy, .done, .weight_first, .weight_second,
  .weight_third, .degenerate
);

// ----- tb/sv/triangle_barycentric_weights_top_tb.sv -----
// Self-checking testbench for triangle_barycentric_weights_top.
// Depends on tbw_pkg and the block RTL; a small scoreboard class predicts weights.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tbw_pkg::*;

  localparam int CW = CoordWidthDef;
  // Covers the pipeline depth of the top level, plus margin.
  localparam int DrainCycles = 40;

  typedef struct {
    logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, px, py;
  } tri_req_t;

  typedef struct {
    logic signed [WeightWidth-1:0] w1, w2, w3;
    logic                          degen;
  } weights_t;

  // Predicts the weights of each request and holds them until the block reports them.
  class weight_scoreboard;
    logic [LimitWidth-1:0] limit;
    weights_t              pending[$];
    int                    failures;

    function new();
      limit    = LimitReset;
      failures = 0;
    endfunction

    // Truncated n * 2^16 / d, magnitude clamped to 2^26.
    static function longint scaled_quot(longint n, longint d);
      longint mag;
      bit     neg;
      neg = (n < 0) != (d < 0);
      mag = ((n < 0 ? -n : n) <<< FracBits) / (d < 0 ? -d : d);
      if (mag > (longint'(1) <<< 26)) mag = longint'(1) <<< 26;
      return neg ? -mag : mag;
    endfunction

    static function logic signed [WeightWidth-1:0] clamp24(longint v);
      if (v > 8388607) return WeightMax;
      if (v < -8388608) return WeightMin;
      return v[WeightWidth-1:0];
    endfunction

    function void note_request(tri_req_t r);
      longint ax, ay, az, bx, by, bz, cx, cy, cz;
      weights_t w;
      ax = r.x3 - r.x1; ay = r.x2 - r.x1; az = r.x1 - r.px;
      bx = r.y3 - r.y1; by = r.y2 - r.y1; bz = r.y1 - r.py;
      cx = ay * bz - az * by;
      cy = az * bx - ax * bz;
      cz = ax * by - ay * bx;
      if ((cz < 0 ? -cz : cz) > longint'(limit)) begin
        w.w1    = clamp24(65536 - scaled_quot(cx + cy, cz));
        w.w2    = clamp24(scaled_quot(cy, cz));
        w.w3    = clamp24(scaled_quot(cx, cz));
        w.degen = 1'b0;
      end else begin
        w.w1    = WeightNegOne;
        w.w2    = WeightOne;
        w.w3    = WeightOne;
        w.degen = 1'b1;
      end
      pending.push_back(w);
    endfunction

    function void check_result(weights_t got);
      weights_t exp_w;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.w1 !== exp_w.w1) begin
        $error("weight_first: expected %0d, got %0d", exp_w.w1, got.w1);
        failures++;
      end
      if (got.w2 !== exp_w.w2) begin
        $error("weight_second: expected %0d, got %0d", exp_w.w2, got.w2);
        failures++;
      end
      if (got.w3 !== exp_w.w3) begin
        $error("weight_third: expected %0d, got %0d", exp_w.w3, got.w3);
        failures++;
      end
      if (got.degen !== exp_w.degen) begin
        $error("degenerate: expected %0d, got %0d", exp_w.degen, got.degen);
        failures++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, limit_we, done, degenerate;
  logic signed [CW-1:0] first_x, first_y, second_x, second_y, third_x, third_y;
  logic signed [CW-1:0] pixel_x, pixel_y;
  logic [LimitWidth-1:0] limit_wdata;
  logic signed [WeightWidth-1:0] weight_first, weight_second, weight_third;

  weight_scoreboard sb = new();

  triangle_barycentric_weights_top #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
    .third_x(third_x), .third_y(third_y), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .limit_we(limit_we), .limit_wdata(limit_wdata),
    .done(done), .weight_first(weight_first), .weight_second(weight_second),
    .weight_third(weight_third), .degenerate(degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2ms;
    $display("triangle_barycentric_weights_top test failed");
    $finish;
  end

  // Results cannot be held off: take every strobe as it comes.
  always @(posedge clk) begin
    weights_t got;
    if (!rst && done) begin
      got.w1    = weight_first;
      got.w2    = weight_second;
      got.w3    = weight_third;
      got.degen = degenerate;
      sb.check_result(got);
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(tri_req_t r);
    start    <= 1'b1;
    first_x  <= r.x1; first_y  <= r.y1;
    second_x <= r.x2; second_y <= r.y2;
    third_x  <= r.x3; third_y  <= r.y3;
    pixel_x  <= r.px; pixel_y  <= r.py;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the pipeline; every request yields exactly one result.
  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_limit(logic [LimitWidth-1:0] v);
    limit_we    <= 1'b1;
    limit_wdata <= v;
    @(posedge clk);
    limit_we    <= 1'b0;
    sb.limit = v;
  endtask

  function automatic tri_req_t make_tri(int x1, int y1, int x2, int y2, int x3, int y3,
                                        int px, int py);
    tri_req_t r;
    r.x1 = CW'(x1); r.y1 = CW'(y1); r.x2 = CW'(x2); r.y2 = CW'(y2);
    r.x3 = CW'(x3); r.y3 = CW'(y3); r.px = CW'(px); r.py = CW'(py);
    return r;
  endfunction

  // Mix full-range noise, small triangles near a random base, and collinear sets.
  function automatic tri_req_t random_tri();
    tri_req_t r;
    int bx, by, span, k;
    k = $urandom_range(0, 9);
    if (k < 3) begin
      r = make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
    end else if (k < 8) begin
      span = (k < 5) ? 8 : (k < 7 ? 256 : 4096);
      bx = $urandom_range(0, 65535) - 32768 + span;
      by = $urandom_range(0, 65535) - 32768 + span;
      if (bx > 32767 - span) bx = 32767 - span;
      if (by > 32767 - span) by = 32767 - span;
      r = make_tri(bx + $urandom_range(0, 2*span) - span, by + $urandom_range(0, 2*span) - span,
                   bx + $urandom_range(0, 2*span) - span, by + $urandom_range(0, 2*span) - span,
                   bx + $urandom_range(0, 2*span) - span, by + $urandom_range(0, 2*span) - span,
                   bx + $urandom_range(0, 2*span) - span, by + $urandom_range(0, 2*span) - span);
    end else begin
      // Collinear vertices: zero area term regardless of pixel.
      bx = $urandom_range(0, 200) - 100;
      by = $urandom_range(0, 200) - 100;
      r = make_tri(bx, by, bx + 3, by + 5, bx - 6, by - 10,
                   $urandom, $urandom);
    end
    return r;
  endfunction

  task automatic random_phase(int count, int idle_pct);
    repeat (count) begin
      while ($urandom_range(0, 99) < idle_pct) idle_cycle();
      send_request(random_tri());
    end
  endtask

  initial begin
    int limits[5];
    int idles[5];
    start       = 1'b0;
    limit_we    = 1'b0;
    limit_wdata = '0;
    {first_x, first_y, second_x, second_y} = '0;
    {third_x, third_y, pixel_x, pixel_y}   = '0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests under the reset limit.
    send_request(make_tri(0, 0, 0, 0, 0, 0, 0, 0));                 // zero area
    send_request(make_tri(0, 0, 1, 0, 0, 2, 5, 5));                 // area equals limit
    send_request(make_tri(0, 0, 1, 0, 0, 3, 0, 0));                 // just above, pixel on vertex
    send_request(make_tri(0, 0, 1, 0, 0, 3, 1, 0));
    send_request(make_tri(0, 0, 1, 0, 0, 3, 0, 3));
    send_request(make_tri(0, 0, 1, 0, 0, 3, 32767, -32768));         // saturating weights
    send_request(make_tri(0, 0, 1, 0, 0, 3, -32768, 32767));
    send_request(make_tri(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
    send_request(make_tri(32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768));
    send_request(make_tri(-32768, 32767, 32767, 32767, 32767, -32768, 32767, 32767));
    send_request(make_tri(16, 16, 160, 16, 16, 160, 48, 48));         // pixel inside
    send_request(make_tri(16, 16, 16, 160, 160, 16, 48, 48));         // opposite winding
    send_request(make_tri(-1, -1, -1, -1, -1, -1, -1, -1));
    send_request(make_tri(0, 0, 4, 4, 8, 8, 3, 1));                   // collinear
    idle_cycle();
    wait_drained();

    // Each phase: write a limit while idle, then random traffic at one idle rate.
    limits = '{0, 65535, 1, 300, 2};
    idles  = '{0, 54, 30, 0, 54};
    foreach (limits[i]) begin
      write_limit(LimitWidth'(limits[i]));
      random_phase(350, idles[i]);
      wait_drained();
    end

    if (sb.failures == 0) begin
      $display("triangle_barycentric_weights_top test passed");
    end else begin
      $display("triangle_barycentric_weights_top test failed");
    end
    $finish;
  end
endmodule
